### hdl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants of the RGB-to-hue core
// Widths, pipeline depth and the beat record that flows through the divider.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int unsigned ChanW        = 8;   // width of one color channel
  localparam int unsigned HueW         = 16;  // hue word, Q0.16 of a turn
  localparam int unsigned NumW         = 11;  // |numerator| and divisor (6*delta)
  localparam int unsigned BitsPerStage = 2;   // quotient bits made per stage
  localparam int unsigned DivStages    = HueW / BitsPerStage;
  localparam int unsigned PrepStages   = 2;
  localparam int unsigned Latency      = PrepStages + DivStages + 1;

  // One beat inside the divider pipeline.
  typedef struct packed {
    logic            vld;   // beat present
    logic            neg;   // numerator was negative (red sector only)
    logic            gray;  // delta is zero, hue forced to zero
    logic [NumW-1:0] rem;   // partial remainder, below dvs unless gray
    logic [NumW-1:0] dvs;   // divisor, 6 * delta
    logic [HueW-1:0] quo;   // quotient bits made so far
  } div_beat_t;

endpackage

### hdl/rth_prep.sv
// ----------------------------------------------------------------------------
// rth_prep: sector and numerator front end
// Two stages: pick max channel and min, then delta, |numerator| and divisor.
// ----------------------------------------------------------------------------
module rth_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rth_pkg::ChanW-1:0] red_i,
  input  logic [rth_pkg::ChanW-1:0] green_i,
  input  logic [rth_pkg::ChanW-1:0] blue_i,
  output rth_pkg::div_beat_t        beat_o
);

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // stage 0
  logic                      vld0_q;
  sector_e                   sector_d, sector_q;
  logic [rth_pkg::ChanW-1:0] mx_d, mx_q, mn_d, mn_q;
  logic [rth_pkg::ChanW-1:0] r_q, g_q, b_q;

  // stage 1
  logic [rth_pkg::ChanW-1:0] delta;
  logic [rth_pkg::NumW:0]    n_wide;
  logic                      neg_d;
  rth_pkg::div_beat_t        beat_d, beat_q;

  always_comb begin
    // ties go red first, then green
    if (red_i >= green_i && red_i >= blue_i) begin
      sector_d = SecRed;
      mx_d     = red_i;
    end else if (green_i >= blue_i) begin
      sector_d = SecGreen;
      mx_d     = green_i;
    end else begin
      sector_d = SecBlue;
      mx_d     = blue_i;
    end
    mn_d = red_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d) mn_d = blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    mx_q     <= mx_d;
    mn_q     <= mn_d;
    r_q      <= red_i;
    g_q      <= green_i;
    b_q      <= blue_i;
  end

  assign delta = mx_q - mn_q;

  always_comb begin
    neg_d  = 1'b0;
    n_wide = '0;
    case (sector_q)
      SecRed: begin
        if (g_q >= b_q) begin
          n_wide = {{(rth_pkg::NumW + 1 - rth_pkg::ChanW){1'b0}}, g_q - b_q};
        end else begin
          n_wide = {{(rth_pkg::NumW + 1 - rth_pkg::ChanW){1'b0}}, b_q - g_q};
          neg_d  = 1'b1;
        end
      end
      SecGreen: begin
        // 2*delta + blue - red, never negative
        n_wide = {3'b000, delta, 1'b0} + {4'b0000, b_q} - {4'b0000, r_q};
      end
      SecBlue: begin
        // 4*delta + red - green, never negative
        n_wide = {2'b00, delta, 2'b00} + {4'b0000, r_q} - {4'b0000, g_q};
      end
      default: begin
        n_wide = '0;
      end
    endcase
  end

  always_comb begin
    beat_d.vld  = vld0_q;
    beat_d.neg  = neg_d;
    beat_d.gray = (delta == '0);
    beat_d.rem  = n_wide[rth_pkg::NumW-1:0];
    beat_d.dvs  = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    beat_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

### hdl/rth_div_stage.sv
// ----------------------------------------------------------------------------
// rth_div_stage: one stage of the restoring divider
// Make two quotient bits per beat by shift, compare and subtract.
// ----------------------------------------------------------------------------
module rth_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rth_pkg::div_beat_t beat_i,
  output rth_pkg::div_beat_t beat_o
);

  rth_pkg::div_beat_t beat_d, beat_q;

  always_comb begin
    logic [rth_pkg::NumW:0] shifted;
    beat_d = beat_i;
    for (int unsigned i = 0; i < rth_pkg::BitsPerStage; i++) begin
      shifted = {beat_d.rem, 1'b0};
      if (shifted >= {1'b0, beat_d.dvs}) begin
        shifted    = shifted - {1'b0, beat_d.dvs};
        beat_d.quo = {beat_d.quo[rth_pkg::HueW-2:0], 1'b1};
      end else begin
        beat_d.quo = {beat_d.quo[rth_pkg::HueW-2:0], 1'b0};
      end
      // remainder stays below the divisor, so the top bit drops
      beat_d.rem = shifted[rth_pkg::NumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

### hdl/rgb_to_hue_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hue_core: HSV hue of an 8-bit RGB pixel
// Fully pipelined hue engine, one pixel per clock, Q0.16 turn fraction out.
// ----------------------------------------------------------------------------
// Drive a pixel on red_i/green_i/blue_i with start_i high; a beat is taken on
// every clock edge where start_i is high, since busy_o never rises. After the
// pipeline registers below, hue_o carries the result for one cycle, flagged
// by done_o, and results come out in the order pixels went in, one per clock
// at most. There is no backpressure: capture hue_o whenever done_o is high.
// The pipeline is two front-end stages (max/min, then delta and numerator),
// eight divider stages producing two quotient bits each, and the output
// register. Hue is n * 65536 / (6 * delta) truncated toward zero, with n the
// signed sector numerator; a negative red-sector value wraps by 65536, and
// gray pixels give zero.
// ----------------------------------------------------------------------------
module rgb_to_hue_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [rth_pkg::ChanW-1:0] red_i,
  input  logic [rth_pkg::ChanW-1:0] green_i,
  input  logic [rth_pkg::ChanW-1:0] blue_i,
  output logic                      done_o,
  output logic [rth_pkg::HueW-1:0]  hue_o
);

  // divider chain: entry 0 comes from the front end
  rth_pkg::div_beat_t chain [rth_pkg::DivStages+1];

  logic                     done_q;
  logic [rth_pkg::HueW-1:0] hue_d, hue_q;

  // every stage advances every cycle, so input is never held off
  assign busy_o = 1'b0;

  rth_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .beat_o  (chain[0])
  );

  for (genvar s = 0; s < rth_pkg::DivStages; s++) begin : g_div
    rth_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain[s]),
      .beat_o (chain[s+1])
    );
  end

  // Final fixup: drop gray pixels to zero, wrap negative red-sector values.
  // Negating a zero quotient gives zero, so no extra test is needed.
  always_comb begin
    if (chain[rth_pkg::DivStages].gray) begin
      hue_d = '0;
    end else if (chain[rth_pkg::DivStages].neg) begin
      hue_d = '0 - chain[rth_pkg::DivStages].quo;
    end else begin
      hue_d = chain[rth_pkg::DivStages].quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[rth_pkg::DivStages].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
  end

  assign done_o = done_q;
  assign hue_o  = hue_q;

`ifndef SYNTHESIS
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(rth_pkg::Latency) done_o)
    else $error("result beat missing after accepted pixel");

  a_no_spurious_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##(rth_pkg::Latency) !done_o)
    else $error("result beat without accepted pixel");

  a_gray_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && red_i == green_i && green_i == blue_i)
      |-> ##(rth_pkg::Latency) (hue_o == '0))
    else $error("gray pixel gave nonzero hue");

  a_pure_red_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && red_i > green_i && green_i == blue_i)
      |-> ##(rth_pkg::Latency) (hue_o == '0))
    else $error("red-only pixel gave nonzero hue");
`endif

endmodule
